// ----- hdl/dsha_pkg.sv -----
package dsha_pkg;

  localparam int COUNT_BITS = 29;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] words8_t;
  typedef logic [15:0][3:0][7:0] block_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    logic load;
    logic step;
  } rnd_ctrl_t;

  localparam words8_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t PAD_WORD = 32'h80000000;
  localparam word_t LEN_DIGEST = 32'h00000100;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- hdl/dsha_round.sv -----
module dsha_round (
  input  logic               clk,
  input  dsha_pkg::rnd_ctrl_t ctrl,
  input  dsha_pkg::block_t   blk,
  input  dsha_pkg::words8_t  cv,
  input  dsha_pkg::word_t    k,
  output dsha_pkg::words8_t  work
);

  dsha_pkg::word_t win [16];
  dsha_pkg::words8_t wv;
  dsha_pkg::word_t w_new;
  dsha_pkg::word_t t1;
  dsha_pkg::word_t t2;
  dsha_pkg::word_t ch;
  dsha_pkg::word_t maj;

  // The window holds the next sixteen schedule words, current one in slot 0.
  always_comb begin
    w_new = dsha_pkg::small_sigma1(win[14]) + win[9] + dsha_pkg::small_sigma0(win[1])
            + win[0];
    ch = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1 = wv[7] + dsha_pkg::big_sigma1(wv[4]) + ch + k + win[0];
    t2 = dsha_pkg::big_sigma0(wv[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int i = 0; i < 16; i++) begin
        win[i] <= blk[i];
      end
      wv <= cv;
    end else if (ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  assign work = wv;

endmodule

// ----- hdl/double_sha256_hasher_unit.sv -----
// Double SHA-256 hasher. The input stream carries one message byte per beat:
// tdata is the byte, tuser says the byte belongs to the message, and tlast
// ends the message (after the byte of the same beat, if any). A beat with
// neither flag changes nothing.
// An ordinary byte is taken in the idle state. Every 64th byte starts one block
// compression on the shared round unit: a load step, the round steps and a
// chaining-add step, during which tready is low.
// At message end the block is padded in the pad state, then two or three
// compressions run (one more when the last block holds 56 bytes or more),
// the last one over the first digest.
// The result is four beats on the output stream: tdata is 64 digest bits,
// most significant part first, tuser is the part number and tlast marks
// part 3. A stalled receiver holds the block in the output state; no new
// byte is taken until all four beats are delivered.
// Reset (synchronous, active high) restores the initial hash words and a zero
// byte count. The count stops at its maximum and further bytes are dropped.
module double_sha256_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // msg_byte
  input  logic        s_axis_tuser,  // has_byte
  input  logic        s_axis_tlast,  // end_of_msg
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // digest_part
  output logic [1:0]  m_axis_tuser,  // part_index
  output logic        m_axis_tlast   // last_part
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA, PH_PAD1, PH_LEN, PH_SECOND
  } phase_t;

  state_t state;
  phase_t phase;
  logic fin_pend;
  logic [5:0] rnd;
  logic [1:0] part;
  dsha_pkg::count_t byte_count;
  dsha_pkg::words8_t cv;
  dsha_pkg::words8_t cv_sum;
  dsha_pkg::words8_t work;
  dsha_pkg::block_t blk;
  dsha_pkg::block_t pad_blk;
  dsha_pkg::word_t len_word;
  dsha_pkg::rnd_ctrl_t ctrl;
  logic [5:0] pos;
  logic take_byte;

  assign pos = byte_count[5:0];
  assign len_word = 32'({byte_count, 3'b000});
  assign take_byte = s_axis_tuser && (byte_count != dsha_pkg::COUNT_MAX);

  assign ctrl.load = (state == ST_LOAD);
  assign ctrl.step = (state == ST_ROUND);

  dsha_round u_round (
    .clk  (clk),
    .ctrl (ctrl),
    .blk  (blk),
    .cv   (cv),
    .k    (dsha_pkg::ROUND_K[rnd]),
    .work (work)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cv_sum[i] = cv[i] + work[i];
    end
  end

  always_comb begin
    pad_blk = blk;
    for (int i = 0; i < 16; i++) begin
      if (4'(i) > pos[5:2]) begin
        pad_blk[i] = '0;
      end else if (4'(i) == pos[5:2]) begin
        for (int j = 0; j < 4; j++) begin
          if (2'(j) == ~pos[1:0]) begin
            pad_blk[i][j] = dsha_pkg::PAD_BYTE;
          end else if (2'(j) < ~pos[1:0]) begin
            pad_blk[i][j] = '0;
          end
        end
      end
    end
    if (pos < 6'd56) begin
      pad_blk[14] = '0;
      pad_blk[15] = len_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_DATA;
      fin_pend <= 1'b0;
      rnd <= '0;
      part <= '0;
      byte_count <= '0;
      cv <= dsha_pkg::INIT_HASH;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (take_byte) begin
              blk[pos[5:2]][~pos[1:0]] <= s_axis_tdata;
              byte_count <= byte_count + 1'b1;
            end
            priority if (take_byte && pos == 6'h3f) begin
              phase <= PH_DATA;
              fin_pend <= s_axis_tlast;
              state <= ST_LOAD;
            end else if (s_axis_tlast) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_PAD: begin
          blk <= pad_blk;
          phase <= (pos >= 6'd56) ? PH_PAD1 : PH_LEN;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          rnd <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          unique case (phase)
            PH_DATA: begin
              cv <= cv_sum;
              fin_pend <= 1'b0;
              state <= fin_pend ? ST_PAD : ST_IDLE;
            end
            PH_PAD1: begin
              cv <= cv_sum;
              blk <= {len_word, 480'd0};
              phase <= PH_LEN;
              state <= ST_LOAD;
            end
            PH_LEN: begin
              for (int i = 0; i < 8; i++) begin
                blk[i] <= cv_sum[i];
              end
              blk[8] <= dsha_pkg::PAD_WORD;
              for (int i = 9; i < 15; i++) begin
                blk[i] <= '0;
              end
              blk[15] <= dsha_pkg::LEN_DIGEST;
              cv <= dsha_pkg::INIT_HASH;
              phase <= PH_SECOND;
              state <= ST_LOAD;
            end
            PH_SECOND: begin
              cv <= cv_sum;
              part <= '0;
              state <= ST_OUT;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            part <= part + 1'b1;
            if (part == 2'd3) begin
              cv <= dsha_pkg::INIT_HASH;
              byte_count <= '0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {cv[{part, 1'b0}], cv[{part, 1'b1}]};
  assign m_axis_tuser = part;
  assign m_axis_tlast = (part == 2'd3);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while digest beats are pending");

  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready && !m_axis_tvalid)
    else $error("message end did not start the finishing sequence");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> byte_count == '0 && s_axis_tready)
    else $error("byte count not cleared after the last digest beat");

  a_out_start: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> m_axis_tuser == 2'd0)
    else $error("digest output did not start at part 0");

endmodule
